[rtl/rtrs_pkg.sv]
`default_nettype none
package rtrs_pkg;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  key_byte;
    logic        key_final;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic        accepted;
    logic [31:0] pkt_word;
    logic [2:0]  word_bytes;
    logic        pkt_end;
    logic [1:0]  timer_cmd;
  } out_item_t;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_TIMER  = 2'd2;

  localparam logic [1:0] TMR_START   = 2'd1;
  localparam logic [1:0] TMR_RESTART = 2'd2;
  localparam logic [1:0] TMR_STOP    = 2'd3;

  localparam logic [1:0] REG_RED_EN  = 2'd0;
  localparam logic [1:0] REG_RED_PT  = 2'd1;
  localparam logic [1:0] REG_TXT_PT  = 2'd2;
  localparam logic [1:0] REG_SEQ     = 2'd3;

  localparam logic [7:0]  RTP_VER   = 8'h80;
  localparam logic [31:0] MAX_AGE   = 32'd16383;
  localparam logic [15:0] SEQ_RESET = 16'h9a81;
  localparam int unsigned MAX_RESULTS = 40;

endpackage
`default_nettype wire

[rtl/realtime_text_redundant_sender.sv]
// Real-time text sender with redundancy. A key byte item is stored in a history ring memory
// and answered by one status item; a send (timer item, or final byte while silent) walks a
// sequencer that emits the RTP header, the RED block headers (when redundancy is on) and the
// text as 32-bit words and then a timer notice, or only a stop notice once the history is
// empty. The history memory is read one byte a cycle, while no word is waiting to leave,
// through a registered read port. One item is worked on at a time. At most 40 results leave
// per item.
`default_nettype none
module realtime_text_redundant_sender #(
  parameter int unsigned HIST_DEPTH  = 128,
  parameter int unsigned GENERATIONS = 3
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  rtrs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output rtrs_pkg::out_item_t out_data_o,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [3:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import rtrs_pkg::*;

  localparam int unsigned AW = $clog2(HIST_DEPTH);
  localparam int unsigned GW = $clog2(GENERATIONS + 1);
  localparam int unsigned SUB_MAX = HIST_DEPTH / GENERATIONS;
  localparam int unsigned CW = $clog2(HIST_DEPTH + 1);
  localparam int unsigned RW = $clog2(MAX_RESULTS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_KEY  = 4'd1;
  localparam logic [3:0] S_STAT = 4'd2;
  localparam logic [3:0] S_SEND = 4'd3;
  localparam logic [3:0] S_HDR  = 4'd4;
  localparam logic [3:0] S_RED  = 4'd5;
  localparam logic [3:0] S_TXT  = 4'd6;
  localparam logic [3:0] S_FLSH = 4'd7;
  localparam logic [3:0] S_TMR  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic        red_en_q;
  logic [6:0]  red_pt_q, txt_pt_q;
  logic [15:0] seq_start_q, seq_q;

  logic [7:0]    hist_mem [HIST_DEPTH];
  logic [7:0]    hist_rd_q;
  logic [AW-1:0] bnd_q [GENERATIONS+1];
  logic [31:0]   stp_q [GENERATIONS+1];
  logic [GW-1:0] gen_q;
  logic          silent_q;
  logic [CW-1:0] sub_q;

  logic [3:0]    state_q;
  in_item_t      item_q;
  out_item_t     obuf_q;
  logic          ovalid_q;
  logic [RW-1:0] nres_q;

  logic [31:0]   acc_w_q;
  logic [2:0]    acc_n_q;
  logic [3:0]    hcnt_q;
  logic [GW-1:0] k_q, idx_q;
  logic [1:0]    rsub_q;
  logic [AW-1:0] rd_ptr_q;
  logic [CW-1:0] left_q;
  logic          rd_pend_q;
  logic          sent_q;
  logic [2:0]    bytes_left_tail;

  logic wr_cfg;
  assign pready = 1'b1;
  assign wr_cfg = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_RED_EN: prdata = {31'd0, red_en_q};
      REG_RED_PT: prdata = {25'd0, red_pt_q};
      REG_TXT_PT: prdata = {25'd0, txt_pt_q};
      default:    prdata = {16'd0, seq_start_q};
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = obuf_q;

  // ring arithmetic
  logic [AW-1:0] cur_pos, room;
  logic          key_ok;
  assign cur_pos = bnd_q[gen_q];
  assign room    = bnd_q[0] - AW'(1) - cur_pos;
  assign key_ok  = (room != '0) && (sub_q < CW'(SUB_MAX));

  logic [AW-1:0] len_plain, len_red;
  assign len_plain = bnd_q[gen_q] - bnd_q[gen_q - GW'(1)];
  assign len_red   = bnd_q[gen_q] - bnd_q[idx_q - GW'(1)];

  logic [31:0]   tdiff;
  logic [AW-1:0] blen;
  logic [15:0]   hw;
  assign tdiff = stp_q[gen_q] - stp_q[k_q];
  assign blen  = bnd_q[k_q] - bnd_q[k_q - GW'(1)];
  assign hw    = 16'((tdiff << 2) | (32'(blen) >> 8));

  logic [7:0] pt_byte;
  assign pt_byte = {silent_q, (red_en_q ? red_pt_q : txt_pt_q)};

  // byte to append this cycle
  logic       push;
  logic [7:0] push_b;
  logic       out_free;
  assign out_free = !ovalid_q || out_ready_i;
  assign bytes_left_tail = acc_n_q;

  always_comb begin
    push = 1'b0;
    push_b = 8'd0;
    unique case (state_q)
      S_HDR: begin
        push = 1'b1;
        unique case (hcnt_q)
          4'd0: push_b = RTP_VER;
          4'd1: push_b = pt_byte;
          4'd2: push_b = seq_q[15:8];
          4'd3: push_b = seq_q[7:0];
          4'd4: push_b = item_q.now_ms[31:24];
          4'd5: push_b = item_q.now_ms[23:16];
          4'd6: push_b = item_q.now_ms[15:8];
          4'd7: push_b = item_q.now_ms[7:0];
          default: push_b = 8'd0;
        endcase
      end
      S_RED: begin
        if (k_q == gen_q) begin
          push = 1'b1;
          push_b = {1'b0, txt_pt_q};
        end else if (tdiff <= MAX_AGE) begin
          push = 1'b1;
          unique case (rsub_q)
            2'd0: push_b = {1'b1, txt_pt_q};
            2'd1: push_b = hw[15:8];
            2'd2: push_b = hw[7:0];
            default: push_b = 8'(32'(blen));
          endcase
        end
      end
      S_TXT: begin
        push = rd_pend_q;
        push_b = hist_rd_q;
      end
      default: ;
    endcase
  end

  // a full word leaves only when another byte follows, so the flush marks the last one
  logic       wout;
  logic [31:0] wval;
  logic [2:0]  wcnt;
  logic        wlast;
  always_comb begin
    wout = 1'b0;
    wval = acc_w_q;
    wcnt = acc_n_q;
    wlast = 1'b0;
    if (state_q == S_FLSH && acc_n_q != 3'd0) begin
      wout = 1'b1;
      wlast = 1'b1;
    end else if (acc_n_q == 3'd4 && push) begin
      wout = 1'b1;
    end
  end

  logic key_wr, txt_adv;
  assign key_wr  = (state_q == S_KEY) && key_ok && out_free;
  assign txt_adv = (state_q == S_TXT) && !wout && (left_q != '0);

  logic ovalid_set;
  always_comb begin
    ovalid_set = 1'b0;
    unique case (state_q)
      S_STAT: ovalid_set = out_free;
      S_HDR, S_RED, S_TXT, S_FLSH: ovalid_set = wout && out_free && (nres_q < RW'(MAX_RESULTS));
      S_FIN: ovalid_set = out_free && (nres_q < RW'(MAX_RESULTS));
      default: ovalid_set = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (key_wr) begin
      hist_mem[cur_pos] <= item_q.key_byte;
    end
    if (txt_adv) begin
      hist_rd_q <= hist_mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (ovalid_set) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_en_q <= 1'b1;
      red_pt_q <= 7'd100;
      txt_pt_q <= 7'd98;
      seq_start_q <= SEQ_RESET;
      seq_q <= SEQ_RESET;
      for (int i = 0; i <= GENERATIONS; i++) begin
        bnd_q[i] <= '0;
        stp_q[i] <= '0;
      end
      gen_q <= GW'(1);
      silent_q <= 1'b1;
      sub_q <= '0;
      state_q <= S_IDLE;
      item_q <= '0;
      obuf_q <= '0;
      nres_q <= '0;
      acc_w_q <= '0;
      acc_n_q <= '0;
      hcnt_q <= '0;
      k_q <= '0;
      idx_q <= '0;
      rsub_q <= '0;
      rd_ptr_q <= '0;
      left_q <= '0;
      rd_pend_q <= 1'b0;
      sent_q <= 1'b0;
    end else begin
      if (wr_cfg) begin
        unique case (paddr[3:2])
          REG_RED_EN: red_en_q <= pwdata[0];
          REG_RED_PT: red_pt_q <= pwdata[6:0];
          REG_TXT_PT: txt_pt_q <= pwdata[6:0];
          default: begin
            seq_start_q <= pwdata[15:0];
            seq_q <= pwdata[15:0];
          end
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q <= in_data_i;
            nres_q <= '0;
            state_q <= in_data_i.req_type ? S_SEND : S_KEY;
          end
        end
        S_KEY: begin
          if (out_free) begin
            if (key_ok) begin
              bnd_q[gen_q] <= cur_pos + AW'(1);
            end
            if (item_q.key_final) sub_q <= '0;
            else if (key_ok) sub_q <= sub_q + CW'(1);
            obuf_q <= '{out_kind: KIND_STATUS, accepted: key_ok, pkt_word: 32'd0,
                        word_bytes: 3'd0, pkt_end: !(item_q.key_final && silent_q),
                        timer_cmd: 2'd0};
            sent_q <= item_q.key_final && silent_q;
            state_q <= S_STAT;
          end
        end
        S_STAT: begin
          if (out_free) begin
            nres_q <= nres_q + RW'(1);
            state_q <= sent_q ? S_SEND : S_IDLE;
          end
        end
        S_SEND: begin
          if (gen_q == GW'(GENERATIONS) && bnd_q[0] == bnd_q[GENERATIONS]) begin
            if (out_free) begin
              silent_q <= 1'b1;
              obuf_q <= '{out_kind: KIND_TIMER, accepted: 1'b0, pkt_word: 32'd0,
                          word_bytes: 3'd0, pkt_end: 1'b1, timer_cmd: TMR_STOP};
              state_q <= S_FIN;
            end
          end else begin
            stp_q[gen_q] <= item_q.now_ms;
            hcnt_q <= '0;
            acc_n_q <= '0;
            acc_w_q <= '0;
            k_q <= GW'(1);
            rsub_q <= '0;
            idx_q <= red_en_q ? GW'(1) : gen_q;
            state_q <= S_HDR;
          end
        end
        S_HDR, S_RED, S_TXT, S_FLSH: begin
          if (wout) begin
            if (out_free) begin
              if (nres_q < RW'(MAX_RESULTS)) begin
                obuf_q <= '{out_kind: KIND_WORD, accepted: 1'b0, pkt_word: wval,
                            word_bytes: wcnt, pkt_end: wlast, timer_cmd: 2'd0};
                nres_q <= nres_q + RW'(1);
              end
              acc_n_q <= '0;
              acc_w_q <= '0;
            end
          end else begin
            if (push) begin
              acc_w_q <= acc_w_q | (32'(push_b) << (5'd24 - {bytes_left_tail[1:0], 3'd0}));
              acc_n_q <= acc_n_q + 3'd1;
            end
            unique case (state_q)
              S_HDR: begin
                hcnt_q <= hcnt_q + 4'd1;
                if (hcnt_q == 4'd11) begin
                  seq_q <= seq_q + 16'd1;
                  state_q <= red_en_q ? S_RED : S_TXT;
                  if (!red_en_q) begin
                    rd_ptr_q <= bnd_q[gen_q - GW'(1)];
                    left_q <= CW'(len_plain);
                    rd_pend_q <= 1'b0;
                  end
                end
              end
              S_RED: begin
                if (k_q == gen_q) begin
                  rd_ptr_q <= bnd_q[idx_q - GW'(1)];
                  left_q <= CW'(len_red);
                  rd_pend_q <= 1'b0;
                  state_q <= S_TXT;
                end else if (tdiff <= MAX_AGE) begin
                  rsub_q <= rsub_q + 2'd1;
                  if (rsub_q == 2'd3) k_q <= k_q + GW'(1);
                end else begin
                  idx_q <= k_q + GW'(1);
                  k_q <= k_q + GW'(1);
                end
              end
              S_TXT: begin
                if (left_q != '0) begin
                  rd_ptr_q <= rd_ptr_q + AW'(1);
                  left_q <= left_q - CW'(1);
                  rd_pend_q <= 1'b1;
                end else begin
                  rd_pend_q <= 1'b0;
                  if (!rd_pend_q) state_q <= S_FLSH;
                end
              end
              default: state_q <= S_TMR;
            endcase
          end
        end
        S_TMR: begin
          if (out_free) begin
            if (gen_q < GW'(GENERATIONS)) begin
              gen_q <= gen_q + GW'(1);
              bnd_q[gen_q + GW'(1)] <= bnd_q[gen_q];
            end else begin
              for (int i = 0; i < GENERATIONS; i++) begin
                bnd_q[i] <= bnd_q[i+1];
                stp_q[i] <= stp_q[i+1];
              end
            end
            obuf_q <= '{out_kind: KIND_TIMER, accepted: 1'b0, pkt_word: 32'd0,
                        word_bytes: 3'd0, pkt_end: 1'b1,
                        timer_cmd: (silent_q ? TMR_START : TMR_RESTART)};
            silent_q <= 1'b0;
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/rtrs_checker.sv]
`default_nettype none
module rtrs_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_ready_o,
  input wire                 out_valid_o,
  input wire                 out_ready_i,
  input rtrs_pkg::out_item_t out_data_o
);
  import rtrs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item changed while stalled");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.out_kind != 2'd3)
    else $error("bad kind");

  a_word_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_kind == KIND_WORD |->
      out_data_o.word_bytes != 3'd0 && out_data_o.word_bytes <= 3'd4)
    else $error("bad byte count");

  a_timer_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_kind == KIND_TIMER |-> out_data_o.pkt_end)
    else $error("timer notice must end the run");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted while busy");

endmodule

bind realtime_text_redundant_sender rtrs_checker u_rtrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

[dv/tb_realtime_text_redundant_sender.sv]
`timescale 1ns / 100ps
module tb_realtime_text_redundant_sender;
  import rtrs_pkg::*;

  localparam int unsigned HD = 128;
  localparam int unsigned GN = 3;

  class text_sender_scoreboard;
    out_item_t  expected_q[$];
    int         mismatches;
    int         results_seen;
    int         packets_seen;
    int         stops_seen;
    bit         red_en;
    logic [6:0] red_pt;
    logic [6:0] txt_pt;
    logic [15:0] seq;
    logic [7:0] hist[HD];
    int unsigned bounds[GN+1];
    logic [31:0] stamps[GN+1];
    int unsigned cur_gen;
    bit         silent;
    int unsigned sub_cnt;
    int         step_cnt;

    function new();
      red_en = 1'b1;
      red_pt = 7'd100;
      txt_pt = 7'd98;
      seq = SEQ_RESET;
      foreach (hist[i]) hist[i] = 8'h00;
      foreach (bounds[i]) bounds[i] = 0;
      foreach (stamps[i]) stamps[i] = '0;
      cur_gen = 1;
      silent = 1'b1;
      sub_cnt = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_RED_EN: red_en = val[0];
        REG_RED_PT: red_pt = val[6:0];
        REG_TXT_PT: txt_pt = val[6:0];
        REG_SEQ: seq = val[15:0];
        default: ;
      endcase
    endfunction

    function void push_result(logic [1:0] kind, logic acc, logic [31:0] word, logic [2:0] nb,
                              logic last, logic [1:0] tcmd);
      out_item_t r;
      if (step_cnt >= MAX_RESULTS) return;
      r.out_kind = kind;
      r.accepted = acc;
      r.pkt_word = word;
      r.word_bytes = nb;
      r.pkt_end = last;
      r.timer_cmd = tcmd;
      expected_q.push_back(r);
      step_cnt++;
    endfunction

    function void predict_send(logic [31:0] now);
      logic [7:0] pk[$];
      int unsigned g, first, start, cplen, bl, len;
      logic [31:0] tdiff, w;
      logic [15:0] hw;
      logic [6:0] pt;
      int unsigned nb;
      g = cur_gen;
      pt = red_en ? red_pt : txt_pt;
      if (g == GN && bounds[0] == bounds[GN]) begin
        silent = 1'b1;
        push_result(KIND_TIMER, 1'b0, '0, '0, 1'b1, TMR_STOP);
        return;
      end
      stamps[g] = now;
      pk.push_back(RTP_VER);
      pk.push_back({silent, pt});
      pk.push_back(seq[15:8]);
      pk.push_back(seq[7:0]);
      for (int k = 0; k < 4; k++) pk.push_back(now[31-8*k -: 8]);
      for (int k = 0; k < 4; k++) pk.push_back(8'h00);
      seq = seq + 16'd1;
      if (red_en) begin
        first = 1;
        for (int unsigned k = 1; k < g; k++) begin
          tdiff = stamps[g] - stamps[k];
          if (tdiff <= MAX_AGE) begin
            bl = (HD + bounds[k] - bounds[k-1]) % HD;
            hw = 16'((tdiff << 2) | (bl >> 8));
            pk.push_back({1'b1, txt_pt});
            pk.push_back(hw[15:8]);
            pk.push_back(hw[7:0]);
            pk.push_back(8'(bl));
          end else begin
            first = k + 1;
          end
        end
        pk.push_back({1'b0, txt_pt});
      end else begin
        first = g;
      end
      start = bounds[first-1] % HD;
      cplen = (HD + bounds[g] - start) % HD;
      for (int unsigned k = 0; k < cplen; k++) pk.push_back(hist[(start + k) % HD]);
      len = pk.size();
      for (int unsigned i = 0; i < len; i += 4) begin
        w = '0;
        nb = (len - i > 4) ? 4 : len - i;
        for (int unsigned k = 0; k < nb; k++) w[31-8*k -: 8] = pk[i+k];
        push_result(KIND_WORD, 1'b0, w, 3'(nb), (i + 4 >= len), 2'd0);
      end
      if (g < GN) begin
        cur_gen = g + 1;
        bounds[g+1] = bounds[g];
      end else begin
        for (int k = 0; k < GN; k++) begin
          bounds[k] = bounds[k+1];
          stamps[k] = stamps[k+1];
        end
      end
      push_result(KIND_TIMER, 1'b0, '0, '0, 1'b1, silent ? TMR_START : TMR_RESTART);
      silent = 1'b0;
    endfunction

    function void note_input(in_item_t it);
      int unsigned pos, room;
      bit acc, sends;
      step_cnt = 0;
      if (it.req_type) begin
        predict_send(it.now_ms);
        return;
      end
      pos = bounds[cur_gen] % HD;
      room = ((HD + bounds[0] - 1) - pos) % HD;
      acc = 1'b0;
      sends = it.key_final && silent;
      if (room > 0 && sub_cnt < HD / GN) begin
        hist[pos] = it.key_byte;
        bounds[cur_gen] = (pos + 1) % HD;
        sub_cnt++;
        acc = 1'b1;
      end
      if (it.key_final) sub_cnt = 0;
      push_result(KIND_STATUS, acc, '0, '0, !sends, 2'd0);
      if (sends) predict_send(it.now_ms);
    endfunction

    function void check_result(out_item_t act);
      out_item_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", act);
        return;
      end
      e = expected_q.pop_front();
      if (act.out_kind == KIND_WORD && act.pkt_end) packets_seen++;
      if (act.out_kind == KIND_TIMER && act.timer_cmd == TMR_STOP) stops_seen++;
      if (act.out_kind !== e.out_kind || act.accepted !== e.accepted ||
          act.pkt_word !== e.pkt_word || act.word_bytes !== e.word_bytes ||
          act.pkt_end !== e.pkt_end || act.timer_cmd !== e.timer_cmd) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp kind %0d acc %0d word %h nb %0d end %0d tmr %0d | act kind %0d acc %0d word %h nb %0d end %0d tmr %0d",
                   e.out_kind, e.accepted, e.pkt_word, e.word_bytes, e.pkt_end, e.timer_cmd,
                   act.out_kind, act.accepted, act.pkt_word, act.word_bytes, act.pkt_end,
                   act.timer_cmd);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  text_sender_scoreboard sb;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_cycles;
  logic [31:0] clock_ms;
  int          items_sent;

  realtime_text_redundant_sender u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic offer_item(logic rt, logic [7:0] kb, logic fin, logic [31:0] now);
    int gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= '{req_type: rt, key_byte: kb, key_final: fin, now_ms: now};
    do @(posedge clk_i); while (!(in_valid && in_ready));
    items_sent++;
  endtask

  task automatic drain;
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  function automatic logic [31:0] advance_ms();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) clock_ms = clock_ms + 32'd20000;
    else if (r < 7) clock_ms = $urandom;
    else if (r < 9) clock_ms = clock_ms - $urandom_range(1, 500);
    else clock_ms = clock_ms + $urandom_range(0, 1500);
    return clock_ms;
  endfunction

  task automatic random_items(int target);
    int start_cnt, len;
    start_cnt = items_sent;
    while (items_sent - start_cnt < target) begin
      if ($urandom_range(0, 99) < 65) begin
        len = ($urandom_range(0, 14) == 0) ? $urandom_range(40, 60) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          offer_item(1'b0, 8'($urandom), (i == len - 1) || ($urandom_range(0, 40) == 0),
                     advance_ms());
      end else begin
        len = $urandom_range(1, 5);
        repeat (len) offer_item(1'b1, 8'($urandom), 1'($urandom), advance_ms());
      end
    end
  endtask

  initial begin
    sb = new();
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    clock_ms = 32'd1000;
    items_sent = 0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, single submissions, timer resends up to the stop
    offer_item(1'b0, 8'h00, 1'b1, 32'h0000_0000);
    offer_item(1'b0, 8'hff, 1'b0, 32'hffff_ffff);
    offer_item(1'b0, 8'h5a, 1'b1, 32'hffff_ffff);
    offer_item(1'b1, 8'h00, 1'b0, 32'd200);
    offer_item(1'b1, 8'hff, 1'b1, 32'd500);
    offer_item(1'b1, 8'h00, 1'b0, 32'd800);
    offer_item(1'b1, 8'h00, 1'b0, 32'd1100);
    offer_item(1'b0, 8'ha5, 1'b1, 32'd1400);
    offer_item(1'b0, 8'h3c, 1'b1, 32'd40000);
    offer_item(1'b1, 8'h00, 1'b0, 32'd40300);
    offer_item(1'b1, 8'h00, 1'b0, 32'd90000);
    offer_item(1'b1, 8'h00, 1'b0, 32'd90300);
    offer_item(1'b1, 8'h00, 1'b0, 32'd90600);
    offer_item(1'b1, 8'h00, 1'b0, 32'd10);
    drain();

    reg_write(REG_RED_EN, 32'd0);
    reg_write(REG_RED_PT, 32'd127);
    reg_write(REG_TXT_PT, 32'd0);
    reg_write(REG_SEQ, 32'hffff);
    fork
      begin
        repeat (20) @(negedge clk_i);
        hold_cycles = 400;
      end
      random_items(100);
    join
    drain();

    send_idle_pct = 69;
    reg_write(REG_RED_EN, 32'd1);
    reg_write(REG_RED_PT, 32'd0);
    reg_write(REG_TXT_PT, 32'd127);
    reg_write(REG_SEQ, 32'd0);
    random_items(100);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 69;
    reg_write(REG_RED_PT, $urandom_range(0, 127));
    reg_write(REG_TXT_PT, $urandom_range(0, 127));
    reg_write(REG_SEQ, $urandom_range(0, 65535));
    random_items(100);
    drain();

    send_idle_pct = 13;
    recv_stall_pct = 13;
    reg_write(REG_RED_EN, $urandom_range(0, 1));
    random_items(100);
    drain();

    $display("covered %0d items, %0d results, %0d packets, %0d timer stops",
             items_sent, sb.results_seen, sb.packets_seen, sb.stops_seen);
    $display("with and without redundancy, extreme payload types and sequence numbers");
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.expected_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/rtrs_pkg.sv
rtl/realtime_text_redundant_sender.sv
rtl/rtrs_checker.sv
dv/tb_realtime_text_redundant_sender.sv
